@@ rtl/core/sha256_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and bit functions of the SHA-256 digest core.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 61;
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS = 8;
    localparam int ROUNDS     = 64;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PAD2,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    function automatic word_t rotr(input word_t v, input int n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sig0(input word_t x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t init_hash(input logic [2:0] idx);
        unique case (idx)
            3'd0: init_hash = 32'h6A09E667;
            3'd1: init_hash = 32'hBB67AE85;
            3'd2: init_hash = 32'h3C6EF372;
            3'd3: init_hash = 32'hA54FF53A;
            3'd4: init_hash = 32'h510E527F;
            3'd5: init_hash = 32'h9B05688C;
            3'd6: init_hash = 32'h1F83D9AB;
            default: init_hash = 32'h5BE0CD19;
        endcase
    endfunction

    function automatic word_t round_k(input logic [5:0] t);
        unique case (t)
            6'd0:  round_k = 32'h428A2F98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hB5C0FBCF;  6'd3:  round_k = 32'hE9B5DBA5;
            6'd4:  round_k = 32'h3956C25B;  6'd5:  round_k = 32'h59F111F1;
            6'd6:  round_k = 32'h923F82A4;  6'd7:  round_k = 32'hAB1C5ED5;
            6'd8:  round_k = 32'hD807AA98;  6'd9:  round_k = 32'h12835B01;
            6'd10: round_k = 32'h243185BE;  6'd11: round_k = 32'h550C7DC3;
            6'd12: round_k = 32'h72BE5D74;  6'd13: round_k = 32'h80DEB1FE;
            6'd14: round_k = 32'h9BDC06A7;  6'd15: round_k = 32'hC19BF174;
            6'd16: round_k = 32'hE49B69C1;  6'd17: round_k = 32'hEFBE4786;
            6'd18: round_k = 32'h0FC19DC6;  6'd19: round_k = 32'h240CA1CC;
            6'd20: round_k = 32'h2DE92C6F;  6'd21: round_k = 32'h4A7484AA;
            6'd22: round_k = 32'h5CB0A9DC;  6'd23: round_k = 32'h76F988DA;
            6'd24: round_k = 32'h983E5152;  6'd25: round_k = 32'hA831C66D;
            6'd26: round_k = 32'hB00327C8;  6'd27: round_k = 32'hBF597FC7;
            6'd28: round_k = 32'hC6E00BF3;  6'd29: round_k = 32'hD5A79147;
            6'd30: round_k = 32'h06CA6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27B70A85;  6'd33: round_k = 32'h2E1B2138;
            6'd34: round_k = 32'h4D2C6DFC;  6'd35: round_k = 32'h53380D13;
            6'd36: round_k = 32'h650A7354;  6'd37: round_k = 32'h766A0ABB;
            6'd38: round_k = 32'h81C2C92E;  6'd39: round_k = 32'h92722C85;
            6'd40: round_k = 32'hA2BFE8A1;  6'd41: round_k = 32'hA81A664B;
            6'd42: round_k = 32'hC24B8B70;  6'd43: round_k = 32'hC76C51A3;
            6'd44: round_k = 32'hD192E819;  6'd45: round_k = 32'hD6990624;
            6'd46: round_k = 32'hF40E3585;  6'd47: round_k = 32'h106AA070;
            6'd48: round_k = 32'h19A4C116;  6'd49: round_k = 32'h1E376C08;
            6'd50: round_k = 32'h2748774C;  6'd51: round_k = 32'h34B0BCB5;
            6'd52: round_k = 32'h391C0CB3;  6'd53: round_k = 32'h4ED8AA4A;
            6'd54: round_k = 32'h5B9CCA4F;  6'd55: round_k = 32'h682E6FF3;
            6'd56: round_k = 32'h748F82EE;  6'd57: round_k = 32'h78A5636F;
            6'd58: round_k = 32'h84C87814;  6'd59: round_k = 32'h8CC70208;
            6'd60: round_k = 32'h90BEFFFA;  6'd61: round_k = 32'hA4506CEB;
            6'd62: round_k = 32'hBEF9A3F7;  default: round_k = 32'hC67178F2;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/sha256_message_digest.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_message_digest
// Byte-streaming SHA-256 hasher with one shared round unit.
// Sequence: a byte beat is taken in IDLE; a beat that fills a block starts the
//   64 rounds of the round unit plus one hash update; a beat with tlast runs a
//   pad step and one block, or a pad step, a block, a length-only pad step and a
//   second block when the length spills into a second block, then 8 digest beats.
// Throughput: one round per cycle through the single round datapath; the
//   input is not ready while a block compresses or the digest drains.
// Reset: rst_n asynchronous, active low; loads the initial hash values and
//   clears the byte count and the sequencer.
// ----------------------------------------------------------------------------
module sha256_message_digest
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] has_byte
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic             m_tlast    // last_word
);

    localparam int NW = sha256_pkg::BLOCK_WORDS;
    localparam int NH = sha256_pkg::HASH_WORDS;

    sha256_pkg::state_t state_reg, state_next;

    // Message schedule window: w_reg[0] is W_t of the current round.
    sha256_pkg::word_t w_reg [NW];
    sha256_pkg::word_t w_next [NW];
    // Hash state and working variables a..h.
    sha256_pkg::word_t h_reg [NH];
    sha256_pkg::word_t h_next [NH];
    sha256_pkg::word_t v_reg [NH];
    sha256_pkg::word_t v_next [NH];

    logic [sha256_pkg::COUNT_W-1:0] count_reg, count_next, count_inc;
    logic [5:0] round_reg, round_next;
    logic [2:0] idx_reg, idx_next;
    logic       last_reg, last_next;      // padding still owed after this block
    logic       final_reg, final_next;    // this block closes the message
    logic       second_reg, second_next;  // a length-only block follows

    logic [5:0]  pos;
    logic [63:0] bit_len;
    sha256_pkg::word_t t1, t2, sched;

    assign pos       = count_reg[5:0];
    assign count_inc = count_reg + 1'b1;
    assign bit_len   = {count_reg, 3'b000};

    // Shared round unit: one compression round plus one schedule word.
    assign t1 = v_reg[7] + sha256_pkg::big_sig1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sha256_pkg::round_k(round_reg) + w_reg[0];
    assign t2 = sha256_pkg::big_sig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign sched = sha256_pkg::sig1(w_reg[14]) + w_reg[9]
                 + sha256_pkg::sig0(w_reg[1]) + w_reg[0];

    assign s_tready = (state_reg == sha256_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == sha256_pkg::ST_OUT);
    assign m_tdata  = {5'b00000, idx_reg, h_reg[idx_reg]};
    assign m_tlast  = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha256_pkg::ST_IDLE;
            count_reg  <= '0;
            round_reg  <= '0;
            idx_reg    <= '0;
            last_reg   <= 1'b0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            for (int i = 0; i < NH; i++)
            begin
                h_reg[i] <= sha256_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            last_reg   <= last_next;
            final_reg  <= final_next;
            second_reg <= second_next;
            h_reg      <= h_next;
        end
    end

    // Block buffer and working variables carry no reset.
    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        final_next  = final_reg;
        second_next = second_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        v_next      = v_reg;

        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    last_next = s_tlast;
                    if (s_tuser)
                    begin
                        // Drop the byte into its big-endian lane.
                        w_next[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = s_tdata;
                        count_next = count_inc;
                    end
                    if (s_tuser && (count_inc[5:0] == 6'd0))
                    begin
                        final_next = 1'b0;
                        round_next = '0;
                        v_next     = h_reg;
                        state_next = sha256_pkg::ST_ROUND;
                    end
                    else if (s_tlast)
                    begin
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end

            sha256_pkg::ST_PAD:
            begin
                // Keep bytes below pos, mark at pos, zero above.
                for (int i = 0; i < NW; i++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        if (6'(4 * i + j) == pos)
                        begin
                            w_next[i][8 * (3 - j) +: 8] = sha256_pkg::PAD_MARK;
                        end
                        else if (6'(4 * i + j) > pos)
                        begin
                            w_next[i][8 * (3 - j) +: 8] = 8'h00;
                        end
                    end
                end
                last_next = 1'b0;
                if (pos < sha256_pkg::LEN_POS)
                begin
                    w_next[NW-2] = bit_len[63:32];
                    w_next[NW-1] = bit_len[31:0];
                    final_next   = 1'b1;
                    second_next  = 1'b0;
                end
                else
                begin
                    final_next  = 1'b0;
                    second_next = 1'b1;
                end
                round_next = '0;
                v_next     = h_reg;
                state_next = sha256_pkg::ST_ROUND;
            end

            sha256_pkg::ST_PAD2:
            begin
                // Length-only block after a mark that left no room.
                for (int i = 0; i < NW - 2; i++)
                begin
                    w_next[i] = '0;
                end
                w_next[NW-2] = bit_len[63:32];
                w_next[NW-1] = bit_len[31:0];
                second_next  = 1'b0;
                final_next   = 1'b1;
                round_next   = '0;
                v_next       = h_reg;
                state_next   = sha256_pkg::ST_ROUND;
            end

            sha256_pkg::ST_ROUND:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                // Advance the schedule window.
                for (int i = 0; i < NW - 1; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[NW-1] = sched;
                round_next = round_reg + 1'b1;
                if (round_reg == 6'(sha256_pkg::ROUNDS - 1))
                begin
                    state_next = sha256_pkg::ST_UPDATE;
                end
            end

            sha256_pkg::ST_UPDATE:
            begin
                for (int i = 0; i < NH; i++)
                begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                if (final_reg)
                begin
                    idx_next   = '0;
                    state_next = sha256_pkg::ST_OUT;
                end
                else if (second_reg)
                begin
                    state_next = sha256_pkg::ST_PAD2;
                end
                else if (last_reg)
                begin
                    state_next = sha256_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end

            sha256_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 3'd7)
                    begin
                        // Restart for the next message.
                        for (int i = 0; i < NH; i++)
                        begin
                            h_next[i] = sha256_pkg::init_hash(3'(i));
                        end
                        count_next = '0;
                        final_next = 1'b0;
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
